// ----- hw/rtl/esd_pkg.sv -----
`default_nettype none

package esd_pkg;

   // Width of the microsecond time base used for edge timing.
   localparam int TIME_BITS = 32;

   // Elapsed time times counts per revolution.
   localparam int PROD_W = TIME_BITS + 16;

   // Divider widths: the largest dividend is |count| * 5760, below 2^44.
   localparam int NUM_W = 44;
   localparam int DEN_W = PROD_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   // Width for comparing the elapsed time against the 20-bit timeout.
   localparam int CMP_W = (TIME_BITS > 20) ? TIME_BITS : 20;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_W = 56;
   localparam int RSP_W = 136;

   // Speed scale: 60e6 microseconds per minute times 16 for four fraction bits.
   localparam logic [29:0] SpeedNum   = 30'd960000000;
   // Angle scale: 360 degrees times 16 for four fraction bits.
   localparam logic [12:0] AngleScale = 13'd5760;
   localparam logic [19:0] RawMax     = 20'hFFFFF;
   localparam logic [39:0] PosMax     = 40'h7F_FFFF_FFFF;
   localparam logic [39:0] PosMin     = 40'h80_0000_0000;
   localparam logic signed [29:0] FiltAlpha = 30'sd71;
   localparam logic signed [29:0] FiltRound = 30'sd512;

   // Configuration register indexes.
   localparam logic [7:0] CsrMotorInverse = 8'd0;
   localparam logic [7:0] CsrCountsPerRev = 8'd1;
   localparam logic [7:0] CsrMaxRpm       = 8'd2;
   localparam logic [7:0] CsrTimeoutUs    = 8'd3;

   // Reset values of the configuration registers.
   localparam logic [15:0] CprReset  = 16'd360;
   localparam logic [15:0] MaxReset  = 16'd300;
   localparam logic [19:0] TmoReset  = 20'd1000;

   // Item kinds carried in req_tuser.
   localparam logic CmdEdge    = 1'b0;
   localparam logic CmdControl = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PREP  = 7'b0000010,
      ST_FILT  = 7'b0000100,
      ST_START = 7'b0001000,
      ST_WAIT  = 7'b0010000,
      ST_FIN   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } esd_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic prep;
      logic filt;
      logic start;
      logic finish;
      logic load;
   } esd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_ctrl;
      logic div_done;
   } esd_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/esd_div.sv -----
`default_nettype none

module esd_div
   import esd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quo
);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_diff;
   logic             ge;

   // One restoring step per cycle; the dividend shifts out as the quotient shifts in.
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[NUM_W-1]};
      ge       = (rem_sh >= {1'b0, den_ff});
      rem_diff = rem_sh - {1'b0, den_ff};
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      done_in  = done_ff;
      if (start) begin
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
         cnt_in  = CNT_W'(NUM_W);
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   // Control state is reset; the operand registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/esd_dpath.sv -----
`default_nettype none

module esd_dpath
   import esd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // Fields from bit 0 up: enc_b_level, now_us, target_rpm, zero pad.
   input  wire logic [REQ_W-1:0]  req_tdata,
   // Fields from bit 0 up: cmd.
   input  wire logic              req_tuser,
   input  wire logic              csr_wr,
   input  wire logic [7:0]        csr_index,
   input  wire logic [31:0]       csr_data,
   input  wire esd_cmd_type       cmd,
   output esd_status_type         status,
   // Fields from bit 0 up: encoder_count, rpm_raw, rpm_filtered, position_deg,
   // feedback_level, pwm_duty, dir_in1, dir_in2, zero pad.
   output logic [RSP_W-1:0]       rsp_tdata,
   // Fields from bit 0 up: drive_valid.
   output logic                   rsp_tuser
);

   // Configuration registers.
   logic        inv_ff, inv_in;
   logic [15:0] cpr_ff, cpr_in;
   logic [15:0] maxr_ff, maxr_in;
   logic [19:0] tmo_ff, tmo_in;

   // Captured item.
   logic               cmd_ff, cmd_in;
   logic               b_ff, b_in;
   logic [31:0]        now_ff, now_in;
   logic signed [15:0] tgt_ff, tgt_in;

   // Block state.
   logic [31:0]          count_ff, count_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic signed [20:0]   raw_ff, raw_in;
   logic signed [20:0]   filt_ff, filt_in;
   logic signed [39:0]   angle_ff, angle_in;

   // Working registers.
   logic              up_ff, up_in;
   logic              enz_ff, enz_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [7:0]        fb_ff, fb_in;
   logic [7:0]        duty_ff, duty_in;
   logic              in1_ff, in1_in;
   logic              in2_ff, in2_in;
   logic              dv_ff, dv_in;

   // Result register.
   logic [31:0] o_count_ff, o_count_in;
   logic [20:0] o_raw_ff, o_raw_in;
   logic [20:0] o_filt_ff, o_filt_in;
   logic [39:0] o_angle_ff, o_angle_in;
   logic [7:0]  o_fb_ff, o_fb_in;
   logic [7:0]  o_duty_ff, o_duty_in;
   logic        o_in1_ff, o_in1_in;
   logic        o_in2_ff, o_in2_in;
   logic        o_dv_ff, o_dv_in;

   // Combinational terms.
   logic [15:0]          cpr_eff, maxr_eff;
   logic [TIME_BITS-1:0] now_t, elapsed;
   logic                 tmo_hit, step_up;
   logic signed [29:0]   fdiff, fprod, fstep;
   logic signed [21:0]   fsum;
   logic [31:0]          cabs;
   logic [44:0]          cmul;
   logic [15:0]          tabs;
   logic [23:0]          tnum;
   logic [20:0]          fabs;
   logic [16:0]          fsh;
   logic [24:0]          fnum;
   logic [19:0]          mag;
   logic                 tgt_pos;

   // Divider ports.
   logic [NUM_W-1:0] a_num, b_num, c_num, a_quo, b_quo, c_quo;
   logic [DEN_W-1:0] a_den, b_den, c_den;
   logic             a_done, b_done, c_done;

   // Operand preparation.
   always_comb begin
      cpr_eff  = (cpr_ff == 16'd0) ? 16'd1 : cpr_ff;
      maxr_eff = (maxr_ff == 16'd0) ? 16'd1 : maxr_ff;
      now_t    = TIME_BITS'(now_ff);
      elapsed  = now_t - last_ff;
      tmo_hit  = (CMP_W'(elapsed) > CMP_W'(tmo_ff));
      step_up  = inv_ff ? b_ff : !b_ff;

      // Filter step: floor((d * 71 + 512) / 1024).
      fdiff = 30'(raw_ff) - 30'(filt_ff);
      fprod = fdiff * FiltAlpha;
      fstep = (fprod + FiltRound) >>> 10;
      fsum  = 22'(filt_ff) + 22'(fstep);

      cabs = count_ff[31] ? (32'd0 - count_ff) : count_ff;
      cmul = 45'(cabs) * 45'(AngleScale);
      tabs = tgt_ff[15] ? (16'd0 - tgt_ff) : tgt_ff;
      tnum = {tabs, 8'd0} - {8'd0, tabs};
      fabs = filt_ff[20] ? (21'd0 - filt_ff) : filt_ff;
      fsh  = fabs[20:4];
      fnum = {fsh, 8'd0} - {8'd0, fsh};

      mag     = (a_quo > NUM_W'(RawMax)) ? RawMax : a_quo[19:0];
      tgt_pos = !tgt_ff[15] && (tgt_ff != 16'sd0);
   end

   // Divider A: speed on an edge, duty on a control update.
   // Divider B: angle. Divider C: feedback level.
   always_comb begin
      a_num = (cmd_ff == CmdControl) ? NUM_W'(tnum) : NUM_W'(SpeedNum);
      a_den = (cmd_ff == CmdControl) ? DEN_W'(maxr_eff) : prod_ff;
      b_num = NUM_W'(cmul);
      b_den = DEN_W'(cpr_eff);
      c_num = NUM_W'(fnum);
      c_den = DEN_W'(maxr_eff);
   end

   esd_div u_div_a (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .num   (a_num),
      .den   (a_den),
      .done  (a_done),
      .quo   (a_quo)
   );

   esd_div u_div_b (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .num   (b_num),
      .den   (b_den),
      .done  (b_done),
      .quo   (b_quo)
   );

   esd_div u_div_c (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .num   (c_num),
      .den   (c_den),
      .done  (c_done),
      .quo   (c_quo)
   );

   // Next-state logic for configuration, item and state registers.
   always_comb begin
      inv_in   = inv_ff;
      cpr_in   = cpr_ff;
      maxr_in  = maxr_ff;
      tmo_in   = tmo_ff;
      cmd_in   = cmd_ff;
      b_in     = b_ff;
      now_in   = now_ff;
      tgt_in   = tgt_ff;
      count_in = count_ff;
      last_in  = last_ff;
      raw_in   = raw_ff;
      filt_in  = filt_ff;
      angle_in = angle_ff;
      up_in    = up_ff;
      enz_in   = enz_ff;
      prod_in  = prod_ff;
      fb_in    = fb_ff;
      duty_in  = duty_ff;
      in1_in   = in1_ff;
      in2_in   = in2_ff;
      dv_in    = dv_ff;

      // Register writes; indexes beyond the list are ignored.
      if (csr_wr) begin
         case (csr_index)
            CsrMotorInverse: inv_in  = csr_data[0];
            CsrCountsPerRev: cpr_in  = csr_data[15:0];
            CsrMaxRpm:       maxr_in = csr_data[15:0];
            CsrTimeoutUs:    tmo_in  = csr_data[19:0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         cmd_in = req_tuser;
         b_in   = req_tdata[0];
         now_in = req_tdata[32:1];
         tgt_in = req_tdata[48:33];
      end

      // Edge: step the count and time the edge. Control: clear a stale speed.
      if (cmd.prep) begin
         if (cmd_ff == CmdEdge) begin
            up_in    = step_up;
            count_in = step_up ? (count_ff + 32'd1) : (count_ff - 32'd1);
            enz_in   = (elapsed != '0);
            prod_in  = PROD_W'(elapsed) * PROD_W'(cpr_eff);
            last_in  = now_t;
         end else if ((tgt_ff == 16'sd0) && tmo_hit) begin
            raw_in = '0;
         end
      end

      if (cmd.filt) begin
         filt_in = 21'(fsum);
      end

      // Collect the quotients.
      if (cmd.finish) begin
         fb_in = (c_quo > NUM_W'(8'hFF)) ? 8'hFF : c_quo[7:0];
         if (cmd_ff == CmdEdge) begin
            if (enz_ff) begin
               raw_in = up_ff ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
               if (!count_ff[31]) begin
                  angle_in = (b_quo > NUM_W'(PosMax)) ? PosMax : b_quo[39:0];
               end else begin
                  angle_in = (b_quo > NUM_W'(PosMin)) ? PosMin : (40'd0 - b_quo[39:0]);
               end
            end
            duty_in = 8'd0;
            in1_in  = 1'b0;
            in2_in  = 1'b0;
            dv_in   = 1'b0;
         end else begin
            duty_in = (a_quo > NUM_W'(8'hFF)) ? 8'hFF : a_quo[7:0];
            in1_in  = tgt_pos ^ inv_ff;
            in2_in  = !(tgt_pos ^ inv_ff);
            dv_in   = 1'b1;
         end
      end
   end

   // Result register loads when the controller hands the transaction out.
   always_comb begin
      o_count_in = o_count_ff;
      o_raw_in   = o_raw_ff;
      o_filt_in  = o_filt_ff;
      o_angle_in = o_angle_ff;
      o_fb_in    = o_fb_ff;
      o_duty_in  = o_duty_ff;
      o_in1_in   = o_in1_ff;
      o_in2_in   = o_in2_ff;
      o_dv_in    = o_dv_ff;
      if (cmd.load) begin
         o_count_in = count_ff;
         o_raw_in   = raw_ff;
         o_filt_in  = filt_ff;
         o_angle_in = angle_ff;
         o_fb_in    = fb_ff;
         o_duty_in  = duty_ff;
         o_in1_in   = in1_ff;
         o_in2_in   = in2_ff;
         o_dv_in    = dv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff   <= 1'b0;
         cpr_ff   <= CprReset;
         maxr_ff  <= MaxReset;
         tmo_ff   <= TmoReset;
         count_ff <= '0;
         last_ff  <= '0;
         raw_ff   <= '0;
         filt_ff  <= '0;
         angle_ff <= '0;
      end else begin
         inv_ff   <= inv_in;
         cpr_ff   <= cpr_in;
         maxr_ff  <= maxr_in;
         tmo_ff   <= tmo_in;
         count_ff <= count_in;
         last_ff  <= last_in;
         raw_ff   <= raw_in;
         filt_ff  <= filt_in;
         angle_ff <= angle_in;
      end
      cmd_ff     <= cmd_in;
      b_ff       <= b_in;
      now_ff     <= now_in;
      tgt_ff     <= tgt_in;
      up_ff      <= up_in;
      enz_ff     <= enz_in;
      prod_ff    <= prod_in;
      fb_ff      <= fb_in;
      duty_ff    <= duty_in;
      in1_ff     <= in1_in;
      in2_ff     <= in2_in;
      dv_ff      <= dv_in;
      o_count_ff <= o_count_in;
      o_raw_ff   <= o_raw_in;
      o_filt_ff  <= o_filt_in;
      o_angle_ff <= o_angle_in;
      o_fb_ff    <= o_fb_in;
      o_duty_ff  <= o_duty_in;
      o_in1_ff   <= o_in1_in;
      o_in2_ff   <= o_in2_in;
      o_dv_ff    <= o_dv_in;
   end

   assign status.is_ctrl  = (cmd_ff == CmdControl);
   assign status.div_done = a_done && b_done && c_done;

   assign rsp_tdata = {4'd0, o_in2_ff, o_in1_ff, o_duty_ff, o_fb_ff, o_angle_ff,
                       o_filt_ff, o_raw_ff, o_count_ff};
   assign rsp_tuser = o_dv_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/esd_ctrl.sv -----
`default_nettype none

module esd_ctrl
   import esd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   input  wire esd_status_type status,
   output esd_cmd_type         cmd
);

   esd_state_type state_ff, state_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;

   // Sequence one item through capture, preparation, division and hand-off.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.is_ctrl ? ST_FILT : ST_START;
         end
         ST_FILT: begin
            cmd.filt = 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output register holds a result until its transaction completes.
   always_comb begin
      if (cmd.load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   // An accepted item always moves on to preparation.
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_PREP))
      else $error("accepted item did not enter preparation");

   // Starting the dividers clears their done flags before the wait begins.
   a_start_clears_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) |=> !status.div_done)
      else $error("divider done flag survived a start");

   // The filter runs only for control updates.
   a_filt_ctrl_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILT) |-> status.is_ctrl)
      else $error("filter step on an encoder edge");

   // A loaded result is presented in the following cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_tvalid_ff)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- hw/rtl/encoder_speed_and_drive.sv -----
// An item passes through capture, preparation, a filter step on control updates only,
// the 44-step restoring dividers, result collection and hand-off to the output register.
// Items are handled one at a time; the next item is accepted while a finished result
// waits in the output register.
// Reset is synchronous and active high: it clears the count, timing, speed and angle
// state, loads the register defaults, and leaves the block ready in the next cycle.
`default_nettype none

module encoder_speed_and_drive
   import esd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0 up: enc_b_level, now_us, target_rpm, zero pad.
   input  wire logic [REQ_W-1:0] req_tdata,
   // Fields from bit 0 up: cmd.
   input  wire logic             req_tuser,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // Fields from bit 0 up: encoder_count, rpm_raw, rpm_filtered, position_deg,
   // feedback_level, pwm_duty, dir_in1, dir_in2, zero pad.
   output logic [RSP_W-1:0]      rsp_tdata,
   // Fields from bit 0 up: drive_valid.
   output logic                  rsp_tuser,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [7:0]       csr_index,
   input  wire logic [31:0]      csr_data
);

   esd_cmd_type    cmd;
   esd_status_type status;
   logic           csr_wr;

   // Register writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   esd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   esd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_wr    (csr_wr),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- sim/encoder_speed_and_drive_test.sv -----
module encoder_speed_and_drive_test;
   import esd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint SpeedScale = 64'd960000000;
   localparam longint RawLimit   = 64'd1048575;
   localparam longint AngleMax   = 64'sd549755813887;
   localparam longint AngleMin   = -64'sd549755813888;
   localparam int     CycleLimit = 1000000;
   localparam int     HoldCycles = 600;

   // One input transaction: an encoder edge or a control update.
   typedef struct packed {
      logic               cmd;
      logic               enc_b;
      logic [31:0]        now_us;
      logic signed [15:0] target;
   } motor_item_type;

   // One result transaction, field by field.
   typedef struct packed {
      logic signed [31:0] count;
      logic signed [20:0] raw;
      logic signed [20:0] filt;
      logic signed [39:0] pos;
      logic [7:0]         level;
      logic [7:0]         duty;
      logic               in1;
      logic               in2;
      logic               drive;
   } drive_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tuser = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [7:0]       csr_index = '0;
   logic [31:0]      csr_data = '0;

   encoder_speed_and_drive dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Predicted block state and configuration.
   logic [31:0] enc_count;
   logic [31:0] last_edge_us;
   int          raw_rpm;
   int          filt_rpm;
   longint      angle_q4;
   logic        cfg_inverse;
   logic [15:0] cfg_cpr;
   logic [15:0] cfg_max_rpm;
   logic [19:0] cfg_timeout;

   motor_item_type   pending_items[$];
   drive_result_type expected_results[$];
   motor_item_type   drive_item;
   motor_item_type   seen_item;
   drive_result_type predicted;
   drive_result_type oldest;

   int          error_count = 0;
   int          items_queued = 0;
   int          items_accepted = 0;
   int          send_idle_pct = 30;
   int          recv_idle_pct = 63;
   int          stall_requests = 0;
   int          stall_served = 0;
   int          stall_left = 0;
   int          cycle_count = 0;
   logic [31:0] cur_time = '0;
   logic        run_b = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Magnitude to a 0..255 level against the full-scale speed.
   function automatic logic [7:0] speed_to_level(input longint mag);
      longint div;
      longint q;
      div = (cfg_max_rpm == 0) ? 64'sd1 : longint'(cfg_max_rpm);
      q = mag * 255 / div;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   // Advance the predicted state by one accepted transaction and form its result.
   task automatic step_motor_model(input motor_item_type it, output drive_result_type res);
      logic [31:0] elapsed;
      longint      cpr;
      longint      mag;
      longint      pos;
      longint      diff;
      longint      fmag;
      int          f;
      logic        up;
      res = '0;
      elapsed = it.now_us - last_edge_us;
      cpr = (cfg_cpr == 0) ? 64'sd1 : longint'(cfg_cpr);
      if (it.cmd == CmdEdge) begin
         up = cfg_inverse ? it.enc_b : !it.enc_b;
         enc_count = up ? enc_count + 32'd1 : enc_count - 32'd1;
         // A same-time edge leaves speed and angle alone.
         if (elapsed != 0) begin
            mag = 0;
            if (longint'(elapsed) <= SpeedScale) mag = SpeedScale / (longint'(elapsed) * cpr);
            if (mag > RawLimit) mag = RawLimit;
            raw_rpm = up ? int'(mag) : -int'(mag);
            pos = longint'($signed(enc_count)) * 5760 / cpr;
            if (pos > AngleMax) pos = AngleMax;
            if (pos < AngleMin) pos = AngleMin;
            angle_q4 = pos;
         end
         last_edge_us = it.now_us;
      end else begin
         // A zero target with stale edges clears the raw speed.
         if (it.target == 0 && elapsed > cfg_timeout) raw_rpm = 0;
         diff = longint'(raw_rpm) - longint'(filt_rpm);
         filt_rpm = filt_rpm + int'((diff * 71 + 512) >>> 10);
         mag = (it.target < 0) ? -longint'(it.target) : longint'(it.target);
         res.duty = speed_to_level(mag);
         if ((it.target > 0) != cfg_inverse) res.in1 = 1'b1;
         else res.in2 = 1'b1;
         res.drive = 1'b1;
      end
      f = filt_rpm;
      fmag = ((f < 0) ? -longint'(f) : longint'(f)) >>> 4;
      if (f > 1048575) f = 1048575;
      if (f < -1048576) f = -1048576;
      res.count = enc_count;
      res.raw = raw_rpm[20:0];
      res.filt = f[20:0];
      res.pos = angle_q4[39:0];
      res.level = speed_to_level(fmag);
   endtask

   task automatic check_result(input drive_result_type want, input logic [RSP_W-1:0] data,
                               input logic user);
      if (data[31:0] !== want.count)
         report_error($sformatf("encoder_count: expected %0d, got %0d",
                                want.count, $signed(data[31:0])));
      if (data[52:32] !== want.raw)
         report_error($sformatf("rpm_raw: expected %0d, got %0d",
                                want.raw, $signed(data[52:32])));
      if (data[73:53] !== want.filt)
         report_error($sformatf("rpm_filtered: expected %0d, got %0d",
                                want.filt, $signed(data[73:53])));
      if (data[113:74] !== want.pos)
         report_error($sformatf("position_deg: expected %0d, got %0d",
                                want.pos, $signed(data[113:74])));
      if (data[121:114] !== want.level)
         report_error($sformatf("feedback_level: expected %0d, got %0d",
                                want.level, data[121:114]));
      if (data[129:122] !== want.duty)
         report_error($sformatf("pwm_duty: expected %0d, got %0d", want.duty, data[129:122]));
      if (data[130] !== want.in1)
         report_error($sformatf("dir_in1: expected %b, got %b", want.in1, data[130]));
      if (data[131] !== want.in2)
         report_error($sformatf("dir_in2: expected %b, got %b", want.in2, data[131]));
      if (user !== want.drive)
         report_error($sformatf("drive_valid: expected %b, got %b", want.drive, user));
   endtask

   // Sender: offers the next pending item, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_item = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= drive_item.cmd;
            req_tdata <= REQ_W'({drive_item.target, drive_item.now_us, drive_item.enc_b});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls plus a long hold-off on request.
   always @(posedge clock) begin
      if (stall_requests != stall_served) begin
         stall_served <= stall_requests;
         stall_left <= HoldCycles;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left != 0) stall_left <= stall_left - 1;
         rsp_tready <= !reset && stall_left == 0 && $urandom_range(99) >= recv_idle_pct;
      end
   end

   // Monitor: checks each result transaction, then predicts each accepted item.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_error("result transaction with nothing expected");
            end else begin
               oldest = expected_results.pop_front();
               check_result(oldest, rsp_tdata, rsp_tuser);
            end
         end
         if (req_tvalid && req_tready) begin
            seen_item.cmd = req_tuser;
            seen_item.enc_b = req_tdata[0];
            seen_item.now_us = req_tdata[32:1];
            seen_item.target = req_tdata[48:33];
            step_motor_model(seen_item, predicted);
            expected_results.push_back(predicted);
            items_accepted++;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic queue_item(input logic cmd, input logic b, input logic [31:0] now,
                             input logic signed [15:0] target);
      motor_item_type it;
      it.cmd = cmd;
      it.enc_b = b;
      it.now_us = now;
      it.target = target;
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic write_reg(input logic [7:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CsrMotorInverse: cfg_inverse = value[0];
         CsrCountsPerRev: cfg_cpr = value[15:0];
         CsrMaxRpm:       cfg_max_rpm = value[15:0];
         CsrTimeoutUs:    cfg_timeout = value[19:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic inv, input logic [15:0] cpr, input logic [15:0] maxr,
                            input logic [19:0] tmo);
      write_reg(CsrMotorInverse, {31'd0, inv});
      write_reg(CsrCountsPerRev, {16'd0, cpr});
      write_reg(CsrMaxRpm, {16'd0, maxr});
      write_reg(CsrTimeoutUs, {12'd0, tmo});
   endtask

   // Wait until every item is taken and every result checked, then let the block settle.
   task automatic drain;
      while (items_accepted != items_queued || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Mostly plausible motion with advancing time, plus some unrelated noise.
   task automatic queue_random(input int n);
      int kind;
      int sel;
      logic [31:0] step;
      logic signed [15:0] target;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(99);
         if (kind < 6) begin
            cur_time = $urandom;
            queue_item(1'($urandom_range(1)), 1'($urandom_range(1)), cur_time,
                       16'($urandom));
         end else begin
            sel = $urandom_range(99);
            if (sel < 10) step = 0;
            else if (sel < 70) step = $urandom_range(1, 3000);
            else if (sel < 90) step = $urandom_range(1, 200000);
            else step = $urandom_range(0, 2000000);
            cur_time = cur_time + step;
            if ($urandom_range(99) < 70) begin
               if ($urandom_range(99) < 5) run_b = !run_b;
               queue_item(CmdEdge, run_b, cur_time, 16'($urandom));
            end else begin
               sel = $urandom_range(99);
               if (sel < 30) target = '0;
               else if (sel < 80) target = 16'($urandom_range(0, 800) - 400);
               else target = 16'($urandom);
               queue_item(CmdControl, 1'($urandom_range(1)), cur_time, target);
            end
         end
      end
   endtask

   initial begin
      cfg_inverse = 1'b0;
      cfg_cpr = CprReset;
      cfg_max_rpm = MaxReset;
      cfg_timeout = TmoReset;
      enc_count = '0;
      last_edge_us = '0;
      raw_rpm = 0;
      filt_rpm = 0;
      angle_q4 = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed items on the reset configuration.
      queue_item(CmdControl, 1'b0, 32'd0, 16'sd0);
      queue_item(CmdEdge, 1'b0, 32'd0, 16'sd0);
      queue_item(CmdEdge, 1'b0, 32'd1, 16'sd0);
      queue_item(CmdEdge, 1'b1, 32'd1, 16'sd0);
      queue_item(CmdEdge, 1'b1, 32'd1001, 16'sd0);
      queue_item(CmdControl, 1'b0, 32'd1500, 16'sd32767);
      queue_item(CmdControl, 1'b1, 32'd1600, -16'sd32768);
      queue_item(CmdControl, 1'b0, 32'd1700, 16'sd300);
      queue_item(CmdControl, 1'b0, 32'd1800, 16'sd150);
      queue_item(CmdControl, 1'b0, 32'd1900, -16'sd1);
      queue_item(CmdControl, 1'b0, 32'd2001, 16'sd0);
      queue_item(CmdControl, 1'b0, 32'd2002, 16'sd0);
      queue_item(CmdEdge, 1'b0, 32'd2500, 16'sd0);
      queue_item(CmdEdge, 1'b0, 32'hFFFF_FFFF, 16'sd0);
      queue_item(CmdEdge, 1'b0, 32'd5, 16'sd0);
      queue_item(CmdControl, 1'b1, 32'hFFFF_FFFF, -16'sd1);
      queue_item(CmdEdge, 1'b1, 32'd960000005, 16'sd0);
      queue_item(CmdEdge, 1'b1, 32'd960000006, 16'sd0);
      for (int i = 0; i < 5; i++) queue_item(CmdControl, 1'b0, 32'd960000100, 16'sd100);
      queue_item(CmdControl, 1'b0, 32'hAAAA_AAAA, 16'sh5555);
      cur_time = 32'd960000100;
      drain();

      // Lowest settings, inverse polarity.
      configure(1'b1, 16'd1, 16'd1, 20'd0);
      queue_random(300);
      drain();

      // Highest settings, timeout beyond its nominal range.
      configure(1'b0, 16'd65535, 16'd65535, 20'hFFFFF);
      queue_random(300);
      drain();

      // Zero counts and zero full scale, idling swapped.
      send_idle_pct = 63;
      recv_idle_pct = 30;
      configure(1'b1, 16'd0, 16'd0, 20'd1000000);
      queue_random(300);
      drain();

      // Random settings.
      configure(1'($urandom_range(1)), 16'($urandom_range(1, 2000)),
                16'($urandom_range(1, 6000)), 20'($urandom_range(0, 20'hFFFFF)));
      queue_random(300);
      drain();

      // No idling, with a long hold-off on results so the input backs up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(1'b0, 16'd360, 16'd300, 20'd1000);
      queue_random(300);
      stall_requests++;
      drain();

      repeat (100) @(posedge clock);
      if (expected_results.size() != 0)
         report_error("expected results left over at end of run");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
